// File: sv/itf_pkg.sv
`timescale 1ns / 1ps

package itf_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_FIELD_DEF  = 63;

    localparam int BASE_W  = 6;
    localparam int WIDTH_W = 6;
    localparam int PREC_W  = 6;
    localparam int FLAG_W  = 7;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int LEN_W   = 8;
    localparam int POS_W   = 6;

    localparam int FL_LEFT   = 0;
    localparam int FL_PLUS   = 1;
    localparam int FL_SPACE  = 2;
    localparam int FL_PREFIX = 3;
    localparam int FL_ZERO   = 4;
    localparam int FL_SIGNED = 5;
    localparam int FL_LOWER  = 6;

    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
    localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
    localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                      input logic lower);
        logic [CHAR_W-1:0] base_ch;
        base_ch = lower ? CH_A_LO : CH_A_UP;
        if (d < 6'd10) begin
            return CH_ZERO + {2'b00, d};
        end else begin
            return base_ch + {2'b00, d} - 8'd10;
        end
    endfunction

endpackage

// File: sv/integer_to_text_formatter.sv
`timescale 1ns / 1ps

// Formats one integer printf style and sends the field one character per result. Each
// digit comes from a shift-subtract divider that retires one quotient bit per cycle; after
// the last digit the states S_SIZE and S_BOUNDS lay out the field, and then one character
// leaves per cycle while the output is not stalled. A bad radix yields a single error
// result instead of a field. The input is stalled for the whole item, but the next
// request is taken while the final character still waits at the output.
module integer_to_text_formatter #(
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF,
    parameter int MAX_FIELD  = itf_pkg::MAX_FIELD_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [VALUE_BITS-1:0]       i_value,
    input  logic [itf_pkg::BASE_W-1:0]  i_base,
    input  logic [itf_pkg::WIDTH_W-1:0] i_width,
    input  logic [itf_pkg::PREC_W-1:0]  i_precision,
    input  logic [itf_pkg::FLAG_W-1:0]  i_format_flags,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [itf_pkg::CHAR_W-1:0]  o_char_out,
    output logic                        o_last,
    output logic                        o_bad_base
);
    import itf_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int ND_W  = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIZE,
        S_BOUNDS,
        S_EMIT,
        S_ERR
    } t_state;

    t_state              r_state;
    logic [VALUE_BITS-1:0] r_quo;
    logic [DIGIT_W-1:0]  r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic [BASE_W-1:0]   r_base;
    logic [WIDTH_W-1:0]  r_width;
    logic [PREC_W-1:0]   r_prec;
    logic                r_left;
    logic                r_zero;
    logic                r_lower;
    logic                r_has_sign;
    logic [CHAR_W-1:0]   r_sign_ch;
    logic [1:0]          r_pre_len;
    logic [ND_W-1:0]     r_nd;
    logic [DIGIT_W-1:0]  r_stack [VALUE_BITS];
    logic [LEN_W-1:0]    r_pad;
    logic [LEN_W-1:0]    r_pz;
    logic [LEN_W-1:0]    r_b1, r_b2, r_b3, r_b5, r_b6;
    logic [POS_W-1:0]    r_len;
    logic [POS_W-1:0]    r_pos;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;
    logic                r_out_bad;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_bad;
    logic [1:0]            w_pre_len;
    logic [DIGIT_W:0]      n_trial;
    logic                  w_ge;
    logic [DIGIT_W-1:0]    n_rem;
    logic [VALUE_BITS-1:0] n_quo;
    logic [LEN_W-1:0]      w_pe;
    logic [LEN_W-1:0]      w_used;
    logic [LEN_W-1:0]      w_pad;
    logic [LEN_W-1:0]      w_b1, w_b2, w_b3, w_b4, w_b5, w_b6, w_b7;
    logic [POS_W-1:0]      w_len;
    logic [LEN_W-1:0]      w_p;
    logic [CHAR_W-1:0]     w_ch;
    logic                  w_pop;
    logic                  w_is_last;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_neg = i_format_flags[FL_SIGNED] && i_value[VALUE_BITS-1];
    assign w_mag = w_neg ? (~i_value + VALUE_BITS'(1)) : i_value;
    assign w_bad = (i_base < BASE_MIN) || (i_base > BASE_MAX);

    always_comb begin
        w_pre_len = 2'd0;
        if (i_format_flags[FL_PREFIX]) begin
            if (i_base == BASE_HEX) begin
                w_pre_len = 2'd2;
            end else if (i_base == BASE_OCT) begin
                w_pre_len = 2'd1;
            end
        end
    end

    assign n_trial = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge    = n_trial >= {1'b0, r_base};
    assign n_rem   = w_ge ? DIGIT_W'(n_trial - {1'b0, r_base}) : n_trial[DIGIT_W-1:0];
    assign n_quo   = {r_quo[VALUE_BITS-2:0], w_ge};

    assign w_pe   = (LEN_W'(r_prec) > LEN_W'(r_nd)) ? LEN_W'(r_prec) : LEN_W'(r_nd);
    assign w_used = w_pe + LEN_W'(r_has_sign) + LEN_W'(r_pre_len);
    assign w_pad  = (LEN_W'(r_width) > w_used) ? (LEN_W'(r_width) - w_used) : '0;

    assign w_b1 = (!r_left && !r_zero) ? r_pad : '0;
    assign w_b2 = w_b1 + LEN_W'(r_has_sign);
    assign w_b3 = w_b2 + LEN_W'(r_pre_len);
    assign w_b4 = w_b3 + (r_zero ? r_pad : '0);
    assign w_b5 = w_b4 + r_pz;
    assign w_b6 = w_b5 + LEN_W'(r_nd);
    assign w_b7 = w_b6 + (r_left ? r_pad : '0);
    assign w_len = (w_b7 > LEN_W'(MAX_FIELD)) ? POS_W'(MAX_FIELD) : w_b7[POS_W-1:0];

    assign w_p       = LEN_W'(r_pos);
    assign w_is_last = (r_pos == (r_len - POS_W'(1)));

    always_comb begin
        w_pop = 1'b0;
        if (w_p < r_b1) begin
            w_ch = CH_SPACE;
        end else if (w_p < r_b2) begin
            w_ch = r_sign_ch;
        end else if (w_p < r_b3) begin
            w_ch = (w_p == r_b2) ? CH_ZERO : (r_lower ? CH_X_LO : CH_X_UP);
        end else if (w_p < r_b5) begin
            w_ch = CH_ZERO;
        end else if (w_p < r_b6) begin
            w_ch  = digit_char(r_stack[0], r_lower);
            w_pop = 1'b1;
        end else begin
            w_ch = CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT) && (r_state != S_ERR)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_quo      <= w_mag;
                        r_rem      <= '0;
                        r_cnt      <= CNT_W'(VALUE_BITS - 1);
                        r_nd       <= '0;
                        r_base     <= i_base;
                        r_width    <= i_width;
                        r_prec     <= i_precision;
                        r_left     <= i_format_flags[FL_LEFT];
                        r_zero     <= i_format_flags[FL_ZERO] && !i_format_flags[FL_LEFT];
                        r_lower    <= i_format_flags[FL_LOWER];
                        r_pre_len  <= w_pre_len;
                        r_has_sign <= w_neg || i_format_flags[FL_PLUS]
                                      || i_format_flags[FL_SPACE];
                        if (w_neg) begin
                            r_sign_ch <= CH_MINUS;
                        end else if (i_format_flags[FL_PLUS]) begin
                            r_sign_ch <= CH_PLUS;
                        end else begin
                            r_sign_ch <= CH_SPACE;
                        end
                        r_state <= w_bad ? S_ERR : S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    if (r_cnt == '0) begin
                        r_stack[0] <= n_rem;
                        for (int i = 1; i < VALUE_BITS; i++) begin
                            r_stack[i] <= r_stack[i-1];
                        end
                        r_nd  <= r_nd + ND_W'(1);
                        r_rem <= '0;
                        r_cnt <= CNT_W'(VALUE_BITS - 1);
                        if (n_quo == '0) begin
                            r_state <= S_SIZE;
                        end
                    end else begin
                        r_rem <= n_rem;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_SIZE: begin
                    r_pad   <= w_pad;
                    r_pz    <= w_pe - LEN_W'(r_nd);
                    r_state <= S_BOUNDS;
                end
                S_BOUNDS: begin
                    r_b1    <= w_b1;
                    r_b2    <= w_b2;
                    r_b3    <= w_b3;
                    r_b5    <= w_b5;
                    r_b6    <= w_b6;
                    r_len   <= w_len;
                    r_pos   <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= w_ch;
                        r_out_last  <= w_is_last;
                        r_out_bad   <= 1'b0;
                        r_pos       <= r_pos + POS_W'(1);
                        if (w_pop) begin
                            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                                r_stack[i] <= r_stack[i+1];
                            end
                        end
                        if (w_is_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= CH_NUL;
                        r_out_last  <= 1'b1;
                        r_out_bad   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_out_char;
    assign o_last      = r_out_last;
    assign o_bad_base  = r_out_bad;

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_base) |-> o_last)
        else $error("error result without last");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but block not busy");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIZE) |-> ((r_nd != '0) && (32'(r_nd) <= VALUE_BITS)))
        else $error("digit count out of range");

    a_midfield_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_state == S_EMIT))
        else $error("field character pending outside emission");

endmodule
